### rtl/fhpa_pkg.sv
// ----------------------------------------------------------------------------
// fhpa_pkg
// Shared types and codes for the handle pool allocator.
// ----------------------------------------------------------------------------
package fhpa_pkg;

  localparam int HANDLE_W     = 6;
  localparam int HANDLE_SPACE = 64;
  localparam int COUNT_W      = 7;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [COUNT_W-1:0]  count_t;

  typedef enum logic [1:0] {
    MODE_ALLOC     = 2'd0,
    MODE_TRY_ALLOC = 2'd1,
    MODE_RELEASE   = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_INVALID   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

endpackage

### rtl/fifo_handle_pool_allocator.sv
// ----------------------------------------------------------------------------
// fifo_handle_pool_allocator
// Handle allocator with a FIFO free list and an in-use map, both in RAM.
// ----------------------------------------------------------------------------
// The result strobe (done) is registered on leaving S_EXEC, which the start transfer enters.
// A new request is accepted only in S_IDLE; S_EXEC does the RAM read-modify-write.
// busy is high in the cycle after a transfer; the receiver cannot stall done.
// Reset: synchronous; clears pointers, counters and in-use valid bits.
// Free queue RAM contents are undefined after reset and only read once written.
module fifo_handle_pool_allocator #(
  parameter int POOL_SIZE = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             mode,
  input  fhpa_pkg::handle_t      handle_in,
  output logic                   done,
  output fhpa_pkg::handle_t      handle_out,
  output logic [1:0]             status
);

  import fhpa_pkg::*;

  localparam int CAPACITY = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
  localparam count_t CAP_C = COUNT_W'(CAPACITY);
  localparam count_t SPACE_C = COUNT_W'(HANDLE_SPACE);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t  state;
  mode_t   mode_r;
  handle_t hin_r;
  count_t  fresh_next;
  handle_t queue_head;
  handle_t queue_tail;
  count_t  queue_count;
  logic [HANDLE_SPACE-1:0] map_valid;

  logic    accept;
  handle_t queue_q;
  logic    map_q;
  logic    in_use;

  logic    q_we;
  logic    m_we;
  handle_t m_waddr;
  logic    m_wdata;

  logic    pop;
  logic    push;
  logic    take_fresh;
  handle_t res_handle;
  status_t res_status;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state == S_EXEC);
  assign in_use = map_valid[hin_r] && map_q;

  fhpa_ram #(.WIDTH(HANDLE_W), .DEPTH(HANDLE_SPACE)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (queue_tail),
    .wdata (hin_r),
    .re    (accept),
    .raddr (queue_head),
    .rdata (queue_q)
  );

  fhpa_ram #(.WIDTH(1), .DEPTH(HANDLE_SPACE)) u_map_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (accept),
    .raddr (handle_in),
    .rdata (map_q)
  );

  always_comb begin
    pop        = 1'b0;
    push       = 1'b0;
    take_fresh = 1'b0;
    res_handle = '0;
    res_status = ST_OK;
    unique case (mode_r)
      MODE_ALLOC: begin
        if (queue_count != '0) begin
          pop        = 1'b1;
          res_handle = queue_q;
        end else if (fresh_next < CAP_C) begin
          take_fresh = 1'b1;
          res_handle = fresh_next[HANDLE_W-1:0];
        end else begin
          res_status = ST_EXHAUSTED;
        end
      end
      MODE_TRY_ALLOC: begin
        if (queue_count != '0) begin
          pop        = 1'b1;
          res_handle = queue_q;
        end else begin
          res_status = ST_NONE;
        end
      end
      MODE_RELEASE: begin
        if (in_use && (queue_count < SPACE_C)) begin
          push = 1'b1;
        end else begin
          res_status = ST_INVALID;
        end
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    q_we    = busy && push;
    m_we    = busy && (pop || push || take_fresh);
    m_waddr = push ? hin_r : res_handle;
    m_wdata = !push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      handle_out  <= '0;
      status      <= '0;
      fresh_next  <= '0;
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      map_valid   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state      <= S_IDLE;
          done       <= 1'b1;
          handle_out <= res_handle;
          status     <= res_status;
          if (m_we) begin
            map_valid[m_waddr] <= 1'b1;
          end
          if (pop) begin
            queue_head  <= queue_head + 1'b1;
            queue_count <= queue_count - 1'b1;
          end
          if (push) begin
            queue_tail  <= queue_tail + 1'b1;
            queue_count <= queue_count + 1'b1;
          end
          if (take_fresh) begin
            fresh_next <= fresh_next + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(mode);
      hin_r  <= handle_in;
    end
  end

endmodule

### rtl/fhpa_ram.sv
// ----------------------------------------------------------------------------
// fhpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fhpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
